/* rtl/core/hsrb_pkg.sv */
// shared types, character codes and helper functions for the hex serial register bridge
package hsrb_pkg;

  localparam int STORE_DEPTH_DEF = 256;

  localparam logic [7:0] CH_UP_W = 8'h57;  // 'W'
  localparam logic [7:0] CH_UP_R = 8'h52;  // 'R'
  localparam logic [7:0] CH_LO_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_LO_R = 8'h72;  // 'r'
  localparam logic [7:0] CH_NL   = 8'h0A;  // newline
  localparam logic       STAT_OK  = 1'b0;
  localparam logic       STAT_ERR = 1'b1;

  typedef enum logic [2:0] {
    PP_IDLE = 3'd0,
    PP_ADDR = 3'd1,
    PP_CNT  = 3'd2,
    PP_DATA = 3'd3,
    PP_EOC  = 3'd4
  } pp_t;

  typedef enum logic [2:0] {
    TX_NONE = 3'd0,
    TX_RCHR = 3'd1,
    TX_HEXH = 3'd2,
    TX_HEXL = 3'd3,
    TX_RNL  = 3'd4,
    TX_Z    = 3'd5,
    TX_STAT = 3'd6,
    TX_NL   = 3'd7
  } tx_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       busy_res;
  } res_t;

  // byte addresses, already wrapped to eight bits; the store maps them to slots
  typedef struct packed {
    logic       we;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic [7:0] rd_addr;
  } store_req_t;

  // {bad, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = {1'b1, 4'h0};
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, 4'(c - 8'h57)};
    end
    return d;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h37 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

/* rtl/core/hsrb_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module hsrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/hsrb_store.sv */
// byte store: ram plus per-entry valid bits so unwritten entries read as zero
module hsrb_store #(
  parameter int STORE_DEPTH = hsrb_pkg::STORE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hsrb_pkg::store_req_t   req,
  output logic [7:0]             rd_data
);

  import hsrb_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [AW-1:0]          slot_lut [256];
  logic [AW-1:0]          wr_slot;
  logic [AW-1:0]          rd_slot;
  logic [STORE_DEPTH-1:0] vld_r;
  logic                   rd_vld_r;
  logic [7:0]             ram_q;

  // byte address to slot, folded at elaboration
  for (genvar k = 0; k < 256; k++) begin : g_slot
    assign slot_lut[k] = AW'(k % STORE_DEPTH);
  end

  assign wr_slot = slot_lut[req.wr_addr];
  assign rd_slot = slot_lut[req.rd_addr];

  hsrb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (wr_slot),
    .wdata (req.wr_data),
    .raddr (rd_slot),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[wr_slot] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_slot];
    end
  end

  assign rd_data = rd_vld_r ? ram_q : 8'h00;

endmodule

/* rtl/core/hsrb_ctrl.sv */
// command parser and reply sequencer; issues store writes and look-ahead reads
module hsrb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic                 command,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           rd_data,
  output hsrb_pkg::res_t       res,
  output hsrb_pkg::store_req_t store_req
);

  import hsrb_pkg::*;

  pp_t        parse_phase_r, parse_phase_nxt;
  tx_t        tx_phase_r, tx_phase_nxt;
  logic       is_read_r, is_read_nxt;
  logic       second_digit_r, second_digit_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic       nibble_bad_r, nibble_bad_nxt;
  logic [7:0] start_addr_r, start_addr_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] byte_index_r, byte_index_nxt;
  logic       header_bad_r, header_bad_nxt;
  logic       ack_status_r, ack_status_nxt;

  logic       do_rx;
  logic       do_tx;
  logic [4:0] dig;
  logic [7:0] pair_val;
  logic       pair_bad;
  logic [7:0] idx_inc;

  assign do_rx    = acc && !command && (tx_phase_r == TX_NONE);
  assign do_tx    = acc && command && (tx_phase_r != TX_NONE);
  assign dig      = hex_digit(rx_byte);
  assign pair_val = {high_nibble_r, dig[3:0]};
  assign pair_bad = nibble_bad_r | dig[4];
  assign idx_inc  = byte_index_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_phase_r  <= PP_IDLE;
      tx_phase_r     <= TX_NONE;
      is_read_r      <= 1'b0;
      second_digit_r <= 1'b0;
      high_nibble_r  <= 4'h0;
      nibble_bad_r   <= 1'b0;
      start_addr_r   <= 8'h00;
      byte_count_r   <= 8'h00;
      byte_index_r   <= 8'h00;
      header_bad_r   <= 1'b0;
      ack_status_r   <= 1'b0;
    end else begin
      parse_phase_r  <= parse_phase_nxt;
      tx_phase_r     <= tx_phase_nxt;
      is_read_r      <= is_read_nxt;
      second_digit_r <= second_digit_nxt;
      high_nibble_r  <= high_nibble_nxt;
      nibble_bad_r   <= nibble_bad_nxt;
      start_addr_r   <= start_addr_nxt;
      byte_count_r   <= byte_count_nxt;
      byte_index_r   <= byte_index_nxt;
      header_bad_r   <= header_bad_nxt;
      ack_status_r   <= ack_status_nxt;
    end
  end

  // next state
  always_comb begin
    parse_phase_nxt  = parse_phase_r;
    tx_phase_nxt     = tx_phase_r;
    is_read_nxt      = is_read_r;
    second_digit_nxt = second_digit_r;
    high_nibble_nxt  = high_nibble_r;
    nibble_bad_nxt   = nibble_bad_r;
    start_addr_nxt   = start_addr_r;
    byte_count_nxt   = byte_count_r;
    byte_index_nxt   = byte_index_r;
    header_bad_nxt   = header_bad_r;
    ack_status_nxt   = ack_status_r;

    if (do_tx) begin
      unique case (tx_phase_r)
        TX_RCHR: begin
          tx_phase_nxt = (byte_count_r == 8'h00) ? TX_RNL : TX_HEXH;
        end
        TX_HEXH: begin
          tx_phase_nxt = TX_HEXL;
        end
        TX_HEXL: begin
          byte_index_nxt = idx_inc;
          tx_phase_nxt   = (idx_inc == byte_count_r) ? TX_RNL : TX_HEXH;
        end
        TX_RNL: begin
          tx_phase_nxt = TX_Z;
        end
        TX_Z: begin
          tx_phase_nxt = TX_STAT;
        end
        TX_STAT: begin
          tx_phase_nxt = TX_NL;
        end
        TX_NL: begin
          tx_phase_nxt = TX_NONE;
        end
        TX_NONE: begin
          tx_phase_nxt = TX_NONE;
        end
      endcase
    end else if (do_rx) begin
      unique case (parse_phase_r) inside
        PP_IDLE: begin
          if (rx_byte == CH_UP_W || rx_byte == CH_UP_R) begin
            is_read_nxt      = (rx_byte == CH_UP_R);
            header_bad_nxt   = 1'b0;
            second_digit_nxt = 1'b0;
            parse_phase_nxt  = PP_ADDR;
          end else begin
            ack_status_nxt = STAT_ERR;
            tx_phase_nxt   = TX_Z;
          end
        end
        PP_EOC: begin
          parse_phase_nxt = PP_IDLE;
          if (rx_byte != CH_NL || (is_read_r && header_bad_r)) begin
            ack_status_nxt = STAT_ERR;
            tx_phase_nxt   = TX_Z;
          end else if (is_read_r) begin
            ack_status_nxt = STAT_OK;
            byte_index_nxt = 8'h00;
            tx_phase_nxt   = TX_RCHR;
          end else begin
            ack_status_nxt = STAT_OK;
            tx_phase_nxt   = TX_Z;
          end
        end
        PP_ADDR, PP_CNT, PP_DATA: begin
          if (!second_digit_r) begin
            high_nibble_nxt  = dig[3:0];
            nibble_bad_nxt   = dig[4];
            second_digit_nxt = 1'b1;
          end else begin
            second_digit_nxt = 1'b0;
            if (parse_phase_r == PP_ADDR) begin
              start_addr_nxt  = pair_val;
              header_bad_nxt  = header_bad_r | pair_bad;
              parse_phase_nxt = PP_CNT;
            end else if (parse_phase_r == PP_CNT) begin
              byte_count_nxt = pair_val;
              header_bad_nxt = header_bad_r | pair_bad;
              byte_index_nxt = 8'h00;
              if (is_read_r) begin
                parse_phase_nxt = PP_EOC;
              end else if (header_bad_r | pair_bad) begin
                ack_status_nxt  = STAT_ERR;
                tx_phase_nxt    = TX_Z;
                parse_phase_nxt = PP_IDLE;
              end else begin
                parse_phase_nxt = (pair_val == 8'h00) ? PP_EOC : PP_DATA;
              end
            end else if (pair_bad) begin
              ack_status_nxt  = STAT_ERR;
              tx_phase_nxt    = TX_Z;
              parse_phase_nxt = PP_IDLE;
            end else begin
              byte_index_nxt = idx_inc;
              if (idx_inc == byte_count_r) begin
                parse_phase_nxt = PP_EOC;
              end
            end
          end
        end
        default: begin
          parse_phase_nxt = PP_IDLE;
        end
      endcase
    end
  end

  // outputs: reply word and store access
  always_comb begin
    res.tx_valid = 1'b0;
    res.tx_byte  = 8'h00;
    res.tx_last  = 1'b0;
    res.busy_res = (tx_phase_nxt != TX_NONE);

    if (do_tx) begin
      res.tx_valid = 1'b1;
      unique case (tx_phase_r)
        TX_RCHR: res.tx_byte = CH_LO_R;
        TX_HEXH: res.tx_byte = hex_char(rd_data[7:4]);
        TX_HEXL: res.tx_byte = hex_char(rd_data[3:0]);
        TX_RNL:  res.tx_byte = CH_NL;
        TX_Z:    res.tx_byte = CH_LO_Z;
        TX_STAT: res.tx_byte = {7'h00, ack_status_r};
        TX_NL: begin
          res.tx_byte = CH_NL;
          res.tx_last = 1'b1;
        end
        TX_NONE: res.tx_byte = 8'h00;
      endcase
    end

    store_req.we      = do_rx && (parse_phase_r == PP_DATA) && second_digit_r && !pair_bad;
    store_req.wr_addr = start_addr_r + byte_index_r;
    store_req.wr_data = pair_val;
    // look ahead: the ram registers the entry that the next word will need
    store_req.rd_addr = start_addr_nxt + byte_index_nxt;
  end

endmodule

/* rtl/core/hex_serial_register_bridge_core.sv */
// top level of the hex serial register bridge: handshake, reply register, store and parser
//
// usage
//   input channel: each word carries in_command and in_rx_byte. command 0 hands
//   the bridge one received character; command 1 offers one transmit slot.
//   output channel: exactly one word per input word, giving out_tx_valid,
//   out_tx_byte, out_tx_last and out_busy_res for that slot or character.
//   reply: registered; the reply word appears in the cycle after its input word is taken.
//   throughput: one word per cycle while out_stall allows. the byte store is read ahead of
//   the slot that prints its hex digits, so the ram's registered read port
//   adds no wait between words.
//   stall: the reply sits in a single output register; while it is held and
//   out_stall is high, in_stall is raised, otherwise a new word is taken in
//   the same cycle the old reply leaves.
//   reset: synchronous, active low; it clears the parser, the reply
//   sequencer and the store's per-entry valid bits, so the store reads as
//   zero everywhere without any clearing sweep.
module hex_serial_register_bridge_core #(
  parameter int STORE_DEPTH = hsrb_pkg::STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last,
  output logic       out_busy_res
);

  import hsrb_pkg::*;

  logic       acc;
  logic       out_valid_r;
  res_t       res;
  res_t       res_r;
  store_req_t store_req;
  logic [7:0] rd_data;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  hsrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .command   (in_command),
    .rx_byte   (in_rx_byte),
    .rd_data   (rd_data),
    .res       (res),
    .store_req (store_req)
  );

  hsrb_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tx_valid = res_r.tx_valid;
  assign out_tx_byte  = res_r.tx_byte;
  assign out_tx_last  = res_r.tx_last;
  assign out_busy_res = res_r.busy_res;

endmodule

/* tb/hex_serial_register_bridge_core_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the hex serial register bridge core
module hex_serial_register_bridge_core_tb;
  import hsrb_pkg::*;

  localparam int DEPTH          = STORE_DEPTH_DEF;
  localparam int CLK_PERIOD     = 12;
  localparam int TARGET_WORDS   = 1100;
  localparam int LONG_HOLD      = 200;
  localparam int SETTLE_CYCLES  = 10;
  localparam int TIMEOUT_CYCLES = 600000;

  typedef enum int {
    FAULT_NONE,
    FAULT_ADDR,
    FAULT_CNT,
    FAULT_DATA,
    FAULT_CLOSE
  } fault_t;

  // tracks the parser, the reply sequencer and the store, and holds the replies still owed
  class reply_tracker;
    pp_t        parse_phase;
    tx_t        tx_phase;
    logic       is_read;
    logic       second_digit;
    logic       nibble_bad;
    logic       header_bad;
    logic       ack_status;
    logic [3:0] high_nibble;
    logic [7:0] start_addr;
    logic [7:0] byte_count;
    logic [7:0] byte_index;
    logic [7:0] store [DEPTH];
    res_t       pending_replies[$];
    int         errors;

    function new();
      parse_phase  = PP_IDLE;
      tx_phase     = TX_NONE;
      is_read      = 1'b0;
      second_digit = 1'b0;
      nibble_bad   = 1'b0;
      header_bad   = 1'b0;
      ack_status   = STAT_OK;
      high_nibble  = 4'h0;
      start_addr   = 8'h00;
      byte_count   = 8'h00;
      byte_index   = 8'h00;
      foreach (store[i]) store[i] = 8'h00;
      errors = 0;
    endfunction

    function int unsigned slot(logic [7:0] offset);
      return ((start_addr + offset) & 8'hFF) % DEPTH;
    endfunction

    // {bad, value} of one ascii digit
    function logic [4:0] nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
      if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
      if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
      return 5'b1_0000;
    endfunction

    function logic [7:0] glyph(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return 8'h41 + 8'(n) - 8'd10;
    endfunction

    function void start_ack(logic status);
      ack_status  = status;
      tx_phase    = TX_Z;
      parse_phase = PP_IDLE;
    endfunction

    function void pair_done(logic [7:0] value, logic bad);
      case (parse_phase)
        PP_ADDR: begin
          start_addr  = value;
          header_bad  = header_bad | bad;
          parse_phase = PP_CNT;
        end
        PP_CNT: begin
          byte_count = value;
          header_bad = header_bad | bad;
          byte_index = 8'h00;
          if (is_read) begin
            parse_phase = PP_EOC;
          end else if (header_bad) begin
            start_ack(STAT_ERR);
          end else if (byte_count == 8'h00) begin
            parse_phase = PP_EOC;
          end else begin
            parse_phase = PP_DATA;
          end
        end
        default: begin
          if (bad) begin
            start_ack(STAT_ERR);
          end else begin
            store[slot(byte_index)] = value;
            byte_index++;
            if (byte_index == byte_count) parse_phase = PP_EOC;
          end
        end
      endcase
    endfunction

    function void receive(logic [7:0] c);
      logic [4:0] d;
      if (parse_phase == PP_IDLE) begin
        if (c == CH_UP_W || c == CH_UP_R) begin
          is_read      = (c == CH_UP_R);
          header_bad   = 1'b0;
          second_digit = 1'b0;
          parse_phase  = PP_ADDR;
        end else begin
          start_ack(STAT_ERR);
        end
      end else if (parse_phase == PP_EOC) begin
        if (c != CH_NL || (is_read && header_bad)) begin
          start_ack(STAT_ERR);
        end else if (is_read) begin
          ack_status  = STAT_OK;
          byte_index  = 8'h00;
          tx_phase    = TX_RCHR;
          parse_phase = PP_IDLE;
        end else begin
          start_ack(STAT_OK);
        end
      end else begin
        d = nibble_of(c);
        if (!second_digit) begin
          high_nibble  = d[3:0];
          nibble_bad   = d[4];
          second_digit = 1'b1;
        end else begin
          second_digit = 1'b0;
          pair_done({high_nibble, d[3:0]}, nibble_bad | d[4]);
        end
      end
    endfunction

    function logic [7:0] transmit(output logic last);
      logic [7:0] b;
      b    = 8'h00;
      last = 1'b0;
      case (tx_phase)
        TX_RCHR: begin
          b = CH_LO_R;
          if (byte_count == 8'h00) tx_phase = TX_RNL;
          else tx_phase = TX_HEXH;
        end
        TX_HEXH: begin
          b = glyph(store[slot(byte_index)][7:4]);
          tx_phase = TX_HEXL;
        end
        TX_HEXL: begin
          b = glyph(store[slot(byte_index)][3:0]);
          byte_index++;
          if (byte_index == byte_count) tx_phase = TX_RNL;
          else tx_phase = TX_HEXH;
        end
        TX_RNL: begin
          b = CH_NL;
          tx_phase = TX_Z;
        end
        TX_Z: begin
          b = CH_LO_Z;
          tx_phase = TX_STAT;
        end
        TX_STAT: begin
          b = {7'd0, ack_status};
          tx_phase = TX_NL;
        end
        default: begin
          b = CH_NL;
          last = 1'b1;
          tx_phase = TX_NONE;
        end
      endcase
      return b;
    endfunction

    // returns 1 when the word was a received byte dropped behind a pending reply
    function bit take_word(logic cmd, logic [7:0] c);
      res_t r;
      logic l;
      bit   dropped;
      r = '0;
      dropped = 1'b0;
      if (cmd) begin
        if (tx_phase != TX_NONE) begin
          r.tx_byte  = transmit(l);
          r.tx_last  = l;
          r.tx_valid = 1'b1;
        end
      end else if (tx_phase == TX_NONE) begin
        receive(c);
      end else begin
        dropped = 1'b1;
      end
      r.busy_res = (tx_phase != TX_NONE);
      pending_replies.push_back(r);
      return dropped;
    endfunction

    function void field_check(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void match_reply(res_t got);
      res_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with nothing expected, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      field_check("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      field_check("tx_byte", want.tx_byte, got.tx_byte);
      field_check("tx_last", 8'(want.tx_last), 8'(got.tx_last));
      field_check("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    endfunction

    function bit reply_pending();
      return tx_phase != TX_NONE;
    endfunction

    function int owed();
      return pending_replies.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_command;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;
  logic       out_tx_last;
  logic       out_busy_res;

  reply_tracker tracker;
  int unsigned  words_taken;
  bit           calm;
  bit           hold_out;
  logic [7:0]   cmd_bytes[$];

  hex_serial_register_bridge_core #(
    .STORE_DEPTH(DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_valid(out_tx_valid),
    .out_tx_byte (out_tx_byte),
    .out_tx_last (out_tx_last),
    .out_busy_res(out_busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // mostly back to back, sometimes short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66));
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return digit_char(4'($urandom));
      2: return $urandom_range(0, 1) ? CH_UP_W : CH_UP_R;
      default: return CH_NL;
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic [7:0] c);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (!tracker.take_word(cmd, c)) words_taken++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  // offer slots until the reply is out, slipping in bytes that must be dropped
  task automatic drain_reply();
    while (tracker.reply_pending()) begin
      if ($urandom_range(0, 9) == 0) send_word(1'b0, 8'($urandom));
      send_word(1'b1, 8'($urandom));
    end
  endtask

  task automatic wait_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.owed() > 0);
  endtask

  task automatic push_pair(input logic [7:0] v, input bit bad);
    bit hi_bad;
    hi_bad = $urandom_range(0, 1);
    cmd_bytes.push_back((bad && hi_bad) ? junk_char() : digit_char(v[7:4]));
    cmd_bytes.push_back((bad && !hi_bad) ? junk_char() : digit_char(v[3:0]));
  endtask

  task automatic run_command(input bit rd, input logic [7:0] addr, input logic [7:0] cnt,
                             input fault_t fault, input bit push_on);
    int   bad_at;
    logic [7:0] closing;
    cmd_bytes.delete();
    cmd_bytes.push_back(rd ? CH_UP_R : CH_UP_W);
    push_pair(addr, fault == FAULT_ADDR);
    push_pair(cnt, fault == FAULT_CNT);
    if (!rd) begin
      bad_at = (cnt > 0) ? $urandom_range(0, cnt - 1) : -1;
      for (int i = 0; i < cnt; i++) push_pair(8'($urandom), fault == FAULT_DATA && i == bad_at);
    end
    do begin
      closing = 8'($urandom);
    end while (closing == CH_NL);
    cmd_bytes.push_back(fault == FAULT_CLOSE ? closing : CH_NL);
    // stop at the first reply unless the rest is meant to be dropped
    while (cmd_bytes.size() > 0 && (push_on || !tracker.reply_pending()))
      send_word(1'b0, cmd_bytes.pop_front());
    drain_reply();
  endtask

  // receiver: random stall, plus one long hold-off when asked
  initial begin
    int unsigned left;
    left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        left = 0;
      end else if (left > 0) begin
        left--;
      end else begin
        left = pick_gap();
        out_stall <= (left > 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.match_reply(res_t'({out_tx_valid, out_tx_byte, out_tx_last, out_busy_res}));
  end

  initial begin
    bit         rd;
    bit         held;
    bit         paused;
    int unsigned sel;
    logic [7:0] addr;
    logic [7:0] cnt;
    fault_t     fault;
    tracker     = new();
    words_taken = 0;
    calm        = 1'b0;
    hold_out    = 1'b0;
    held        = 1'b0;
    paused      = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = 1'b0;
    in_rx_byte  = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // slot with nothing pending, then a wrapping write of both data extremes
    send_word(1'b1, 8'h00);
    send_text("WfF0200FF\n");
    send_word(1'b0, 8'hFF);
    drain_reply();
    send_text("RFF02\n");
    drain_reply();
    // unknown command byte
    send_word(1'b0, 8'h00);
    drain_reply();

    while (words_taken < TARGET_WORDS) begin
      calm = (words_taken >= 300 && words_taken < 450);
      if (!held && words_taken >= 600) begin
        held = 1'b1;
        hold_out = 1'b1;
      end
      if (!paused && words_taken >= 800) begin
        paused = 1'b1;
        wait_replies();
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        rd   = $urandom_range(0, 1);
        addr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255)) : 8'($urandom);
        sel  = $urandom_range(0, 99);
        if (sel < 80) cnt = 8'($urandom_range(0, 4));
        else if (sel < 98) cnt = 8'($urandom_range(5, 20));
        else cnt = 8'($urandom_range(64, 255));
        fault = ($urandom_range(0, 9) < 7) ? FAULT_NONE : fault_t'($urandom_range(1, 4));
        run_command(rd, addr, cnt, fault, $urandom_range(0, 9) == 0);
      end else if (sel < 87) begin
        repeat ($urandom_range(1, 6)) send_word(1'b0, noise_char());
        drain_reply();
      end else begin
        send_word(1'b1, 8'($urandom));
      end
    end

    wait_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
